[sv/prf_pkg.sv]
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants for the planar rectangle fill block
// Holds the section encoding, register indexes, the clipped-rectangle record
// and the plane mask helper.
// ----------------------------------------------------------------------------
package prf_pkg;

   localparam int unsigned CoordW   = 10;
   localparam int unsigned BandW    = 8;
   localparam int unsigned PlaneW   = 2;
   localparam int unsigned AddrW    = 16;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_CLIP_MIN_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_CLIP_MAX_X = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_CLIP_MIN_Y = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_CLIP_MAX_Y = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_LINE_BYTES = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_PAGE_BASE  = 3'd5;

   // Request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic [3:0] MASK_ALL = 4'hF;

   typedef enum logic [1:0] {
      SEC_LEFT   = 2'd0,
      SEC_MIDDLE = 2'd1,
      SEC_RIGHT  = 2'd2
   } section_type;

   typedef struct packed {
      logic [CoordW-1:0] min_x;
      logic [CoordW-1:0] max_x;
      logic [CoordW-1:0] min_y;
      logic [CoordW-1:0] max_y;
   } clip_window_type;

   typedef struct packed {
      logic              empty;
      logic [BandW-1:0]  first_band;
      logic [BandW-1:0]  final_band;
      logic [PlaneW-1:0] first_plane;
      logic [PlaneW-1:0] final_plane;
      logic [CoordW-1:0] start_row;
      logic [CoordW-1:0] end_row;
   } rect_type;

   // Planes lo..hi inclusive within one band
   function automatic logic [3:0] lane_mask(input logic [PlaneW-1:0] lo,
                                            input logic [PlaneW-1:0] hi);
      logic [3:0] low_part;
      logic [3:0] high_part;
      low_part  = MASK_ALL << lo;
      high_part = MASK_ALL >> (2'd3 - hi);
      return low_part & high_part;
   endfunction

endpackage

[sv/prf_clip.sv]
// ----------------------------------------------------------------------------
// prf_clip: clip a rectangle to the window
// Turns a signed origin and size into band and plane bounds plus row range,
// flagging a rectangle that clips to nothing.
// ----------------------------------------------------------------------------
module prf_clip (
   input  logic signed [11:0]      rect_x,
   input  logic signed [11:0]      rect_y,
   input  logic [10:0]             rect_width,
   input  logic [10:0]             rect_height,
   input  prf_pkg::clip_window_type window,
   output prf_pkg::rect_type       rect
);

   logic signed [13:0] x1;
   logic signed [13:0] y1;
   logic signed [13:0] x2;
   logic signed [13:0] y2;
   logic signed [13:0] x1_c;
   logic signed [13:0] y1_c;
   logic signed [13:0] x2_c;
   logic signed [13:0] y2_c;
   logic signed [13:0] min_x;
   logic signed [13:0] max_x;
   logic signed [13:0] min_y;
   logic signed [13:0] max_y;

   always_comb begin
      x1    = $signed({{2{rect_x[11]}}, rect_x});
      y1    = $signed({{2{rect_y[11]}}, rect_y});
      x2    = x1 + $signed({3'b000, rect_width}) - 14'sd1;
      y2    = y1 + $signed({3'b000, rect_height}) - 14'sd1;
      min_x = $signed({4'b0000, window.min_x});
      max_x = $signed({4'b0000, window.max_x});
      min_y = $signed({4'b0000, window.min_y});
      max_y = $signed({4'b0000, window.max_y});

      x1_c = (x1 < min_x) ? min_x : x1;
      x2_c = (x2 > max_x) ? max_x : x2;
      y1_c = (y1 < min_y) ? min_y : y1;
      y2_c = (y2 > max_y) ? max_y : y2;

      // bounds are only meaningful when not empty; then all lie in 0..1023
      rect.empty       = (y2_c < y1_c) || (x2_c < x1_c);
      rect.first_band  = x1_c[9:2];
      rect.final_band  = x2_c[9:2];
      rect.first_plane = x1_c[1:0];
      rect.final_plane = x2_c[1:0];
      rect.start_row   = y1_c[9:0];
      rect.end_row     = y2_c[9:0];
   end

endmodule

[sv/planar_rect_fill.sv]
// ----------------------------------------------------------------------------
// planar_rect_fill: rectangle fill engine for four-plane video memory
// Clips a rectangle to a window and walks it as byte writes with plane masks.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_*: one register write per beat (index, data); always ready. Write the
//    clip window, line pitch and page base while no rectangle is in flight.
//  - req_*: a start beat (req_type 0) loads a rectangle and colour; it gives
//    no result and replaces any unfinished rectangle. An empty clip leaves the
//    engine idle. Each step beat (req_type 1) then yields one write beat on
//    rsp_*; a step while idle is dropped.
//  - Write order: left band column top to bottom, middle bands row by row
//    with all planes, right band column. rsp_last marks the final write.
//  - Timing: each step's write is registered when the step is accepted. One
//    beat per cycle is sustained while rsp_ready holds high; the only path per
//    item is one 10x8 multiply plus add for the address and counter advance.
//  - Stall: while rsp_valid is high and rsp_ready low, req_ready drops and
//    the write register holds.
//  - Reset clears the engine to idle, empties the write register and loads
//    the default window (0..319 by 0..199), pitch 80 and page base 0.
// ----------------------------------------------------------------------------
module planar_rect_fill (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic signed [11:0] req_rect_x,
   input  logic signed [11:0] req_rect_y,
   input  logic [10:0]        req_rect_width,
   input  logic [10:0]        req_rect_height,
   input  logic [7:0]         req_fill_value,
   // write channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_write_addr,
   output logic [3:0]         rsp_plane_mask,
   output logic [7:0]         rsp_write_data,
   output logic               rsp_last
);

   // configuration registers
   logic [9:0]  clip_min_x_ff;
   logic [9:0]  clip_max_x_ff;
   logic [9:0]  clip_min_y_ff;
   logic [9:0]  clip_max_y_ff;
   logic [7:0]  line_bytes_ff;
   logic [15:0] page_base_ff;

   // walk state
   logic                  busy_ff,        busy_in;
   prf_pkg::section_type  section_ff,     section_in;
   logic [9:0]            cur_row_ff,     cur_row_in;
   logic [7:0]            cur_band_ff,    cur_band_in;
   logic [9:0]            start_row_ff,   start_row_in;
   logic [9:0]            end_row_ff,     end_row_in;
   logic [7:0]            first_band_ff,  first_band_in;
   logic [7:0]            final_band_ff,  final_band_in;
   logic [1:0]            first_plane_ff, first_plane_in;
   logic [1:0]            final_plane_ff, final_plane_in;
   logic [7:0]            colour_ff,      colour_in;

   // write register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] addr_ff;
   logic [3:0]  mask_ff;
   logic [7:0]  data_ff;
   logic        last_ff;

   prf_pkg::clip_window_type window;
   prf_pkg::rect_type        rect;

   logic        req_fire;
   logic        step_fire;
   logic [17:0] row_offset;
   logic [15:0] step_addr;
   logic [3:0]  step_mask;
   logic        step_done;
   logic        single_band;
   logic [8:0]  band_next;
   logic [8:0]  band_span_min;

   // ---------------------------------------------------------------------
   // Configuration: always ready, unknown indexes dropped
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_min_x_ff <= 10'd0;
         clip_max_x_ff <= 10'd319;
         clip_min_y_ff <= 10'd0;
         clip_max_y_ff <= 10'd199;
         line_bytes_ff <= 8'd80;
         page_base_ff  <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            prf_pkg::CSR_CLIP_MIN_X: clip_min_x_ff <= csr_data[9:0];
            prf_pkg::CSR_CLIP_MAX_X: clip_max_x_ff <= csr_data[9:0];
            prf_pkg::CSR_CLIP_MIN_Y: clip_min_y_ff <= csr_data[9:0];
            prf_pkg::CSR_CLIP_MAX_Y: clip_max_y_ff <= csr_data[9:0];
            prf_pkg::CSR_LINE_BYTES: line_bytes_ff <= csr_data[7:0];
            prf_pkg::CSR_PAGE_BASE:  page_base_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Clip the incoming rectangle
   // ---------------------------------------------------------------------
   assign window.min_x = clip_min_x_ff;
   assign window.max_x = clip_max_x_ff;
   assign window.min_y = clip_min_y_ff;
   assign window.max_y = clip_max_y_ff;

   prf_clip u_clip (
      .rect_x      (req_rect_x),
      .rect_y      (req_rect_y),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .window      (window),
      .rect        (rect)
   );

   // ---------------------------------------------------------------------
   // Handshake: take a beat whenever the write register is free or draining
   // ---------------------------------------------------------------------
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign step_fire = req_fire && (req_type == prf_pkg::REQ_STEP) && busy_ff;

   // ---------------------------------------------------------------------
   // Write produced by the current walk position
   // ---------------------------------------------------------------------
   assign single_band   = (first_band_ff == final_band_ff);
   assign band_next     = {1'b0, cur_band_ff} + 9'd1;
   assign band_span_min = {1'b0, first_band_ff} + 9'd2;
   assign row_offset    = cur_row_ff * line_bytes_ff;
   assign step_addr     = page_base_ff + row_offset[15:0] + {8'd0, cur_band_ff};

   always_comb begin
      unique case (section_ff)
         prf_pkg::SEC_LEFT: begin
            step_mask = single_band
                      ? prf_pkg::lane_mask(first_plane_ff, final_plane_ff)
                      : prf_pkg::lane_mask(first_plane_ff, 2'd3);
            step_done = (cur_row_ff >= end_row_ff) && single_band;
         end
         prf_pkg::SEC_MIDDLE: begin
            step_mask = prf_pkg::MASK_ALL;
            step_done = 1'b0;
         end
         prf_pkg::SEC_RIGHT: begin
            step_mask = prf_pkg::lane_mask(2'd0, final_plane_ff);
            step_done = (cur_row_ff >= end_row_ff);
         end
         default: begin
            step_mask = prf_pkg::MASK_ALL;
            step_done = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Next walk state
   // ---------------------------------------------------------------------
   always_comb begin
      busy_in        = busy_ff;
      section_in     = section_ff;
      cur_row_in     = cur_row_ff;
      cur_band_in    = cur_band_ff;
      start_row_in   = start_row_ff;
      end_row_in     = end_row_ff;
      first_band_in  = first_band_ff;
      final_band_in  = final_band_ff;
      first_plane_in = first_plane_ff;
      final_plane_in = final_plane_ff;
      colour_in      = colour_ff;

      if (req_fire && (req_type == prf_pkg::REQ_START)) begin
         // a start always abandons the running rectangle
         busy_in = 1'b0;
         if (!rect.empty) begin
            busy_in        = 1'b1;
            section_in     = prf_pkg::SEC_LEFT;
            first_band_in  = rect.first_band;
            final_band_in  = rect.final_band;
            first_plane_in = rect.first_plane;
            final_plane_in = rect.final_plane;
            start_row_in   = rect.start_row;
            end_row_in     = rect.end_row;
            cur_row_in     = rect.start_row;
            cur_band_in    = rect.first_band;
            colour_in      = req_fill_value;
         end
      end else if (step_fire) begin
         unique case (section_ff)
            prf_pkg::SEC_LEFT: begin
               priority if (cur_row_ff < end_row_ff) begin
                  cur_row_in = cur_row_ff + 10'd1;
               end else if (single_band) begin
                  busy_in = 1'b0;
               end else if ({1'b0, final_band_ff} >= band_span_min) begin
                  section_in  = prf_pkg::SEC_MIDDLE;
                  cur_row_in  = start_row_ff;
                  cur_band_in = first_band_ff + 8'd1;
               end else begin
                  section_in  = prf_pkg::SEC_RIGHT;
                  cur_row_in  = start_row_ff;
                  cur_band_in = final_band_ff;
               end
            end
            prf_pkg::SEC_MIDDLE: begin
               priority if (band_next < {1'b0, final_band_ff}) begin
                  cur_band_in = band_next[7:0];
               end else if (cur_row_ff < end_row_ff) begin
                  cur_row_in  = cur_row_ff + 10'd1;
                  cur_band_in = first_band_ff + 8'd1;
               end else begin
                  section_in  = prf_pkg::SEC_RIGHT;
                  cur_row_in  = start_row_ff;
                  cur_band_in = final_band_ff;
               end
            end
            prf_pkg::SEC_RIGHT: begin
               if (cur_row_ff < end_row_ff) begin
                  cur_row_in = cur_row_ff + 10'd1;
               end else begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         section_ff     <= prf_pkg::SEC_LEFT;
         cur_row_ff     <= 10'd0;
         cur_band_ff    <= 8'd0;
         start_row_ff   <= 10'd0;
         end_row_ff     <= 10'd0;
         first_band_ff  <= 8'd0;
         final_band_ff  <= 8'd0;
         first_plane_ff <= 2'd0;
         final_plane_ff <= 2'd0;
         colour_ff      <= 8'd0;
      end else begin
         busy_ff        <= busy_in;
         section_ff     <= section_in;
         cur_row_ff     <= cur_row_in;
         cur_band_ff    <= cur_band_in;
         start_row_ff   <= start_row_in;
         end_row_ff     <= end_row_in;
         first_band_ff  <= first_band_in;
         final_band_ff  <= final_band_in;
         first_plane_ff <= first_plane_in;
         final_plane_ff <= final_plane_in;
         colour_ff      <= colour_in;
      end
   end

   // ---------------------------------------------------------------------
   // Write register: load on a step, hold while stalled
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         addr_ff <= step_addr;
         mask_ff <= step_mask;
         data_ff <= colour_ff;
         last_ff <= step_done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_write_addr = addr_ff;
   assign rsp_plane_mask = mask_ff;
   assign rsp_write_data = data_ff;
   assign rsp_last       = last_ff;

endmodule
